### sv/h264fua_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Shared widths, register indexes, FU-A header codes and result types.
// ----------------------------------------------------------------------------
package h264fua_pkg;

  localparam int SIZE_BITS    = 24;
  localparam int PAYLOAD_BITS = 16;
  localparam int MAX_RESULTS  = 3;
  localparam int CNT_BITS     = 2;
  localparam int CFG_ADDR_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PAYLOAD = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SINGLE_NAL  = 1'd1;

  localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = PAYLOAD_BITS'(1460);
  localparam logic [PAYLOAD_BITS-1:0] MIN_PAYLOAD       = PAYLOAD_BITS'(3);
  localparam logic [PAYLOAD_BITS-1:0] FU_OVERHEAD       = PAYLOAD_BITS'(2);

  // FU-A codes
  localparam logic [4:0] FU_A_TYPE = 5'd28;
  localparam logic [7:0] FU_S_BIT  = 8'h80;
  localparam logic [7:0] FU_E_BIT  = 8'h40;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;
    logic       rtp_marker;
    logic       drop_error;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] res;
    logic [CNT_BITS-1:0]    count;
  } step_t;

endpackage
`default_nettype wire

### sv/h264fua_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer core
// Holds the per-unit state and turns one NAL byte into up to three results.
// ----------------------------------------------------------------------------
module h264fua_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                fire,
  input  wire logic [7:0]                          nal_byte,
  input  wire logic                                nal_first,
  input  wire logic [h264fua_pkg::SIZE_BITS-1:0]   nal_size,
  input  wire logic                                access_unit_end,
  input  wire logic [h264fua_pkg::PAYLOAD_BITS-1:0] max_payload,
  input  wire logic                                single_nal_only,
  output h264fua_pkg::step_t                       step
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SINGLE,
    MODE_FRAG,
    MODE_DROP
  } mode_t;

  mode_t                                  unit_mode, unit_mode_next;
  logic [h264fua_pkg::SIZE_BITS-1:0]      bytes_left, bytes_left_next;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0]   fragment_left, fragment_left_next;
  logic [1:0]                             saved_nri, saved_nri_next;
  logic [4:0]                             saved_type, saved_type_next;
  logic                                   unit_marker, unit_marker_next;

  logic [h264fua_pkg::PAYLOAD_BITS-1:0]   eff_max;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0]   frag_max;
  logic [h264fua_pkg::SIZE_BITS-1:0]      unit_size;
  logic [h264fua_pkg::SIZE_BITS-1:0]      size_dec;
  logic [h264fua_pkg::SIZE_BITS-1:0]      left_dec;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0]   frag_cur;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0]   frag_dec;
  logic                                   frag_tail;
  logic                                   last_pkt;
  logic [7:0]                             fu_ind;

  assign eff_max   = (max_payload < h264fua_pkg::MIN_PAYLOAD) ?
                     h264fua_pkg::MIN_PAYLOAD : max_payload;
  assign frag_max  = eff_max - h264fua_pkg::FU_OVERHEAD;
  assign unit_size = (nal_size == '0) ? h264fua_pkg::SIZE_BITS'(1) : nal_size;
  assign size_dec  = unit_size - h264fua_pkg::SIZE_BITS'(1);
  assign left_dec  = bytes_left - h264fua_pkg::SIZE_BITS'(1);
  assign last_pkt  = (left_dec == '0);
  // the remainder of the unit fits the next fragment
  assign frag_tail = (bytes_left <= h264fua_pkg::SIZE_BITS'(frag_max));
  assign frag_cur  = (fragment_left != '0) ? fragment_left :
                     (frag_tail ? bytes_left[h264fua_pkg::PAYLOAD_BITS-1:0] : frag_max);
  assign frag_dec  = frag_cur - h264fua_pkg::PAYLOAD_BITS'(1);

  always_comb begin
    unit_mode_next     = unit_mode;
    bytes_left_next    = bytes_left;
    fragment_left_next = fragment_left;
    saved_nri_next     = saved_nri;
    saved_type_next    = saved_type;
    unit_marker_next   = unit_marker;
    step               = '0;
    fu_ind             = {1'b0, saved_nri, h264fua_pkg::FU_A_TYPE};

    if (nal_first) begin
      unit_marker_next   = access_unit_end;
      saved_nri_next     = nal_byte[6:5];
      saved_type_next    = nal_byte[4:0];
      fragment_left_next = '0;
      bytes_left_next    = size_dec;
      if (unit_size <= h264fua_pkg::SIZE_BITS'(eff_max)) begin
        unit_mode_next = (size_dec != '0) ? MODE_SINGLE : MODE_IDLE;
        step.res[0]    = '{data_byte: nal_byte, packet_start: 1'b1,
                           packet_end: (size_dec == '0),
                           rtp_marker: (size_dec == '0) && access_unit_end,
                           drop_error: 1'b0};
        step.count     = h264fua_pkg::CNT_BITS'(1);
      end else if (single_nal_only) begin
        unit_mode_next = MODE_DROP;
        step.res[0]    = '{data_byte: 8'h00, packet_start: 1'b0, packet_end: 1'b0,
                           rtp_marker: 1'b0, drop_error: 1'b1};
        step.count     = h264fua_pkg::CNT_BITS'(1);
      end else begin
        unit_mode_next     = MODE_FRAG;
        fragment_left_next = frag_max;
        step.res[0]        = '{data_byte: {1'b0, nal_byte[6:5], h264fua_pkg::FU_A_TYPE},
                               packet_start: 1'b1, packet_end: 1'b0,
                               rtp_marker: 1'b0, drop_error: 1'b0};
        step.res[1]        = '{data_byte: h264fua_pkg::FU_S_BIT | {3'b000, nal_byte[4:0]},
                               packet_start: 1'b0, packet_end: 1'b0,
                               rtp_marker: 1'b0, drop_error: 1'b0};
        step.count         = h264fua_pkg::CNT_BITS'(2);
      end
    end else begin
      unique case (unit_mode)
        MODE_SINGLE: begin
          bytes_left_next = left_dec;
          if (last_pkt) unit_mode_next = MODE_IDLE;
          step.res[0] = '{data_byte: nal_byte, packet_start: 1'b0, packet_end: last_pkt,
                          rtp_marker: last_pkt && unit_marker, drop_error: 1'b0};
          step.count  = h264fua_pkg::CNT_BITS'(1);
        end
        MODE_DROP: begin
          bytes_left_next = left_dec;
          if (last_pkt) unit_mode_next = MODE_IDLE;
        end
        MODE_FRAG: begin
          bytes_left_next    = left_dec;
          fragment_left_next = last_pkt ? '0 : frag_dec;
          if (last_pkt) unit_mode_next = MODE_IDLE;
          if (fragment_left == '0) begin
            // new fragment: FU indicator and FU header ahead of the byte
            step.res[0] = '{data_byte: fu_ind, packet_start: 1'b1, packet_end: 1'b0,
                            rtp_marker: 1'b0, drop_error: 1'b0};
            step.res[1] = '{data_byte: (frag_tail ? h264fua_pkg::FU_E_BIT : 8'h00) |
                                       {3'b000, saved_type},
                            packet_start: 1'b0, packet_end: 1'b0,
                            rtp_marker: 1'b0, drop_error: 1'b0};
            step.res[2] = '{data_byte: nal_byte, packet_start: 1'b0,
                            packet_end: last_pkt || (frag_dec == '0),
                            rtp_marker: last_pkt && unit_marker, drop_error: 1'b0};
            step.count  = h264fua_pkg::CNT_BITS'(3);
          end else begin
            step.res[0] = '{data_byte: nal_byte, packet_start: 1'b0,
                            packet_end: last_pkt || (frag_dec == '0),
                            rtp_marker: last_pkt && unit_marker, drop_error: 1'b0};
            step.count  = h264fua_pkg::CNT_BITS'(1);
          end
        end
        MODE_IDLE: begin
          // stray byte with no open unit: ignored
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode     <= MODE_IDLE;
      bytes_left    <= '0;
      fragment_left <= '0;
      saved_nri     <= '0;
      saved_type    <= '0;
      unit_marker   <= 1'b0;
    end else if (fire) begin
      unit_mode     <= unit_mode_next;
      bytes_left    <= bytes_left_next;
      fragment_left <= fragment_left_next;
      saved_nri     <= saved_nri_next;
      saved_type    <= saved_type_next;
      unit_marker   <= unit_marker_next;
    end
  end

endmodule
`default_nettype wire

### sv/h264_fua_packetizer.sv
// A byte transfer is registered in the input register; once the result buffer is free the
//   core processes it, and its results are registered in the result buffer and offered.
// Throughput: one byte per cycle while each byte gives one result and out_stall is low; a
//   byte that gives 2 or 3 results (FU-A headers) stalls the input until its last result transfers.
// Reset (rst, synchronous): unit state idle, result buffer empty,
//   max_payload 1460, single_nal_only 0.
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer
// NAL byte stream in, RTP payload bytes out: single NAL packets or FU-A.
// ----------------------------------------------------------------------------
module h264_fua_packetizer (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [h264fua_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [h264fua_pkg::PAYLOAD_BITS-1:0]  cfg_wdata,
  // NAL byte input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [7:0]                            nal_byte,
  input  wire logic                                  nal_first,
  input  wire logic [h264fua_pkg::SIZE_BITS-1:0]     nal_size,
  input  wire logic                                  access_unit_end,
  // payload output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [7:0]                                 data_byte,
  output logic                                       packet_start,
  output logic                                       packet_end,
  output logic                                       rtp_marker,
  output logic                                       drop_error,
  output logic                                       run_last
);

  logic [h264fua_pkg::PAYLOAD_BITS-1:0] max_payload;
  logic                                 single_nal_only;

  // input register
  logic                                 in_held;
  logic [7:0]                           in_byte;
  logic                                 in_first;
  logic [h264fua_pkg::SIZE_BITS-1:0]    in_size;
  logic                                 in_au_end;

  // result buffer
  h264fua_pkg::res_t [h264fua_pkg::MAX_RESULTS-1:0] slot;
  logic [h264fua_pkg::CNT_BITS-1:0]     slot_cnt;
  logic [h264fua_pkg::CNT_BITS-1:0]     slot_idx;
  logic                                 slot_last;
  logic                                 out_xfer;
  logic                                 buf_free;
  logic                                 fire;
  h264fua_pkg::step_t                   step;
  h264fua_pkg::res_t                    cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload     <= h264fua_pkg::MAX_PAYLOAD_RESET;
      single_nal_only <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        h264fua_pkg::REG_MAX_PAYLOAD: max_payload     <= cfg_wdata;
        h264fua_pkg::REG_SINGLE_NAL:  single_nal_only <= cfg_wdata[0];
      endcase
    end
  end

  assign slot_last = (slot_idx == slot_cnt - h264fua_pkg::CNT_BITS'(1));
  assign out_xfer  = out_valid && !out_stall;
  // buffer can take the next item's results this cycle
  assign buf_free  = !out_valid || (out_xfer && slot_last);
  assign fire      = in_held && buf_free;
  assign in_stall  = in_held && !buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_held <= 1'b1;
    end else if (fire) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte   <= nal_byte;
      in_first  <= nal_first;
      in_size   <= nal_size;
      in_au_end <= access_unit_end;
    end
  end

  h264fua_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .nal_byte        (in_byte),
    .nal_first       (in_first),
    .nal_size        (in_size),
    .access_unit_end (in_au_end),
    .max_payload     (max_payload),
    .single_nal_only (single_nal_only),
    .step            (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot_cnt  <= '0;
      slot_idx  <= '0;
    end else if (fire && step.count != '0) begin
      out_valid <= 1'b1;
      slot_cnt  <= step.count;
      slot_idx  <= '0;
    end else if (out_xfer) begin
      if (slot_last) begin
        out_valid <= 1'b0;
      end else begin
        slot_idx <= slot_idx + h264fua_pkg::CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.count != '0) begin
      slot <= step.res;
    end
  end

  always_comb begin
    cur = slot[0];
    case (slot_idx)
      2'd1:    cur = slot[1];
      2'd2:    cur = slot[2];
      default: cur = slot[0];
    endcase
  end

  assign data_byte    = cur.data_byte;
  assign packet_start = cur.packet_start;
  assign packet_end   = cur.packet_end;
  assign rtp_marker   = cur.rtp_marker;
  assign drop_error   = cur.drop_error;
  assign run_last     = slot_last;

endmodule
`default_nettype wire

### sv/h264fua_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module h264fua_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] data_byte,
  input wire logic       packet_start,
  input wire logic       packet_end,
  input wire logic       rtp_marker,
  input wire logic       drop_error,
  input wire logic       run_last
);

  // a drop report stands alone: no payload framing, ends its item
  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && drop_error |->
      run_last && !packet_start && !packet_end && !rtp_marker && data_byte == 8'h00)
    else $error("drop report carries payload framing");

  // marker only on a packet's last byte
  a_marker_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && rtp_marker |-> packet_end)
    else $error("rtp_marker without packet_end");

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(data_byte) && $stable(packet_end) && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind h264_fua_packetizer h264fua_checker u_h264fua_checker (.*);
`default_nettype wire

### tb/tb_h264_fua_packetizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer testbench
// Sends NAL byte streams with random gaps and output stalls under several
// max_payload and single-NAL settings. A built-in packetizer model predicts
// every payload byte and its framing flags, and each output transfer is
// checked in order against it.
// ----------------------------------------------------------------------------
module tb_h264_fua_packetizer;

  localparam int ITEM_TARGET    = 210;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [h264fua_pkg::CFG_ADDR_BITS-1:0] REG_MAX_PAYLOAD =
    h264fua_pkg::REG_MAX_PAYLOAD;
  localparam logic [h264fua_pkg::CFG_ADDR_BITS-1:0] REG_SINGLE_NAL =
    h264fua_pkg::REG_SINGLE_NAL;

  typedef enum logic [1:0] {UNIT_IDLE, UNIT_SINGLE, UNIT_FRAG, UNIT_DROP} unit_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  // CHK_PRED: model decides; CHK_NONE: no output; CHK_ONE: the one typed result
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct {
    h264fua_pkg::res_t res;
    logic              run_last;
  } payload_t;

  typedef struct {
    row_kind_e                                kind;
    logic [h264fua_pkg::CFG_ADDR_BITS-1:0]    reg_idx;
    logic [h264fua_pkg::PAYLOAD_BITS-1:0]     reg_val;
    logic [7:0]                               b;
    logic                                     first;
    logic [h264fua_pkg::SIZE_BITS-1:0]        len;
    logic                                     au;
    row_check_e                               chk;
    h264fua_pkg::res_t                        res;
  } step_row_t;

  logic                                  clk;
  logic                                  rst = 1'b1;
  logic                                  cfg_we = 1'b0;
  logic [h264fua_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0]  cfg_wdata = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [7:0]                            nal_byte = '0;
  logic                                  nal_first = 1'b0;
  logic [h264fua_pkg::SIZE_BITS-1:0]     nal_size = '0;
  logic                                  access_unit_end = 1'b0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [7:0]                            data_byte;
  logic                                  packet_start;
  logic                                  packet_end;
  logic                                  rtp_marker;
  logic                                  drop_error;
  logic                                  run_last;

  // packetizer model state and registers
  logic [h264fua_pkg::PAYLOAD_BITS-1:0] max_payload_q = h264fua_pkg::MAX_PAYLOAD_RESET;
  logic                                 single_only_q = 1'b0;
  logic [h264fua_pkg::SIZE_BITS-1:0]    nal_left_q = '0;
  logic [h264fua_pkg::PAYLOAD_BITS-1:0] frag_left_q = '0;
  unit_mode_e                           unit_q = UNIT_IDLE;
  logic [1:0]                           nri_q = '0;
  logic [4:0]                           nal_type_q = '0;
  logic                                 marker_q = 1'b0;

  payload_t payload_q[$];
  int       fail_count = 0;
  int       sent_items = 0;
  int       in_burst = 0;
  int       out_burst = 0;
  int       quiet_cycles = 0;

  step_row_t directed_rows [30] = '{
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h55, 1'b0, 24'd0, 1'b0, CHK_NONE, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'hFF, 1'b1, 24'd1, 1'b1, CHK_ONE,
      '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h00, 1'b1, 24'd0, 1'b0, CHK_ONE,
      '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h65, 1'b1, 24'd3, 1'b1, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'hFF, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h41, 1'b1, 24'd4, 1'b1, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h9A, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    // abandons the open unit
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h21, 1'b1, 24'd2, 1'b1, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'hE5, 1'b1, 24'hFFFFFF, 1'b1, CHK_PRED, '0},
    '{ROW_CFG, REG_MAX_PAYLOAD, 16'd0, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h7C, 1'b1, 24'd6, 1'b1, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h01, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h02, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    // next fragment of the open unit is cut with the new limit
    '{ROW_CFG, REG_MAX_PAYLOAD, 16'hFFFF, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h03, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h04, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h05, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_CFG, REG_SINGLE_NAL, 16'd1, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h68, 1'b1, 24'h00FFFF, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h06, 1'b1, 24'h010000, 1'b1, CHK_ONE,
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ROW_CFG, REG_MAX_PAYLOAD, 16'd3, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h67, 1'b1, 24'd4, 1'b1, CHK_ONE,
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h55, 1'b0, 24'd0, 1'b0, CHK_NONE, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'hAA, 1'b0, 24'hFFFFFF, 1'b1, CHK_NONE, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h5A, 1'b0, 24'd0, 1'b0, CHK_NONE, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h33, 1'b0, 24'd0, 1'b0, CHK_NONE, '0},
    '{ROW_CFG, REG_SINGLE_NAL, 16'd0, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_CFG, REG_MAX_PAYLOAD, 16'd2, 8'h00, 1'b0, 24'd0, 1'b0, CHK_PRED, '0},
    '{ROW_ITEM, REG_MAX_PAYLOAD, 16'd0, 8'h09, 1'b1, 24'd3, 1'b1, CHK_PRED, '0}
  };

  h264_fua_packetizer i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .nal_byte        (nal_byte),
    .nal_first       (nal_first),
    .nal_size        (nal_size),
    .access_unit_end (access_unit_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .packet_start    (packet_start),
    .packet_end      (packet_end),
    .rtp_marker      (rtp_marker),
    .drop_error      (drop_error),
    .run_last        (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 16));
  endfunction

  function automatic void add_result(logic [7:0] b, logic ps, logic pe, logic mk, logic err);
    payload_t p;
    p.res.data_byte    = b;
    p.res.packet_start = ps;
    p.res.packet_end   = pe;
    p.res.rtp_marker   = mk;
    p.res.drop_error   = err;
    p.run_last         = 1'b0;
    payload_q.push_back(p);
  endfunction

  // Advance the packetizer model by one NAL byte; returns the number of
  // payload results queued for it.
  function automatic int packetize(logic [7:0] b, logic first,
                                   logic [h264fua_pkg::SIZE_BITS-1:0] len, logic au);
    logic [h264fua_pkg::PAYLOAD_BITS-1:0] cap;
    logic [h264fua_pkg::PAYLOAD_BITS-1:0] frag_cap;
    logic [h264fua_pkg::SIZE_BITS-1:0]    nal_len;
    logic [h264fua_pkg::PAYLOAD_BITS-1:0] frag_len;
    int                                   base;
    logic                                 last_pkt;
    base     = payload_q.size();
    cap      = (max_payload_q < h264fua_pkg::MIN_PAYLOAD) ? h264fua_pkg::MIN_PAYLOAD :
               max_payload_q;
    frag_cap = cap - h264fua_pkg::FU_OVERHEAD;
    if (first) begin
      nal_len     = (len == '0) ? h264fua_pkg::SIZE_BITS'(1) : len;
      marker_q    = au;
      nri_q       = b[6:5];
      nal_type_q  = b[4:0];
      frag_left_q = '0;
      nal_left_q  = nal_len - h264fua_pkg::SIZE_BITS'(1);
      if (nal_len <= h264fua_pkg::SIZE_BITS'(cap)) begin
        unit_q = (nal_left_q != '0) ? UNIT_SINGLE : UNIT_IDLE;
        add_result(b, 1'b1, nal_left_q == '0, (nal_left_q == '0) && marker_q, 1'b0);
      end else if (single_only_q) begin
        unit_q = UNIT_DROP;
        add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      end else begin
        frag_left_q = frag_cap;
        unit_q      = UNIT_FRAG;
        add_result({1'b0, nri_q, h264fua_pkg::FU_A_TYPE}, 1'b1, 1'b0, 1'b0, 1'b0);
        add_result(h264fua_pkg::FU_S_BIT | {3'b000, nal_type_q}, 1'b0, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      case (unit_q)
        UNIT_SINGLE: begin
          nal_left_q = nal_left_q - h264fua_pkg::SIZE_BITS'(1);
          if (nal_left_q == '0) unit_q = UNIT_IDLE;
          add_result(b, 1'b0, nal_left_q == '0, (nal_left_q == '0) && marker_q, 1'b0);
        end
        UNIT_DROP: begin
          nal_left_q = nal_left_q - h264fua_pkg::SIZE_BITS'(1);
          if (nal_left_q == '0) unit_q = UNIT_IDLE;
        end
        UNIT_FRAG: begin
          // a fresh fragment gets its indicator and header ahead of the byte
          if (frag_left_q == '0) begin
            frag_len    = (nal_left_q < h264fua_pkg::SIZE_BITS'(frag_cap)) ?
                          nal_left_q[h264fua_pkg::PAYLOAD_BITS-1:0] : frag_cap;
            frag_left_q = frag_len;
            add_result({1'b0, nri_q, h264fua_pkg::FU_A_TYPE}, 1'b1, 1'b0, 1'b0, 1'b0);
            add_result(((h264fua_pkg::SIZE_BITS'(frag_len) == nal_left_q) ?
                        h264fua_pkg::FU_E_BIT : 8'h00) | {3'b000, nal_type_q},
                       1'b0, 1'b0, 1'b0, 1'b0);
          end
          frag_left_q = frag_left_q - h264fua_pkg::PAYLOAD_BITS'(1);
          nal_left_q  = nal_left_q - h264fua_pkg::SIZE_BITS'(1);
          last_pkt    = (nal_left_q == '0);
          if (last_pkt) begin
            frag_left_q = '0;
            unit_q      = UNIT_IDLE;
          end
          add_result(b, 1'b0, frag_left_q == '0, last_pkt && marker_q, 1'b0);
        end
        default: ;
      endcase
    end
    if (payload_q.size() > base) payload_q[$].run_last = 1'b1;
    return payload_q.size() - base;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic first,
                           input logic [h264fua_pkg::SIZE_BITS-1:0] len, input logic au,
                           output int n);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    nal_byte        <= b;
    nal_first       <= first;
    nal_size        <= len;
    access_unit_end <= au;
    do @(posedge clk); while (in_stall);
    n = packetize(b, first, len, au);
    sent_items++;
  endtask

  // Only with nothing in flight: drain, give a byte without output time to
  // settle, then write.
  task automatic write_reg(input logic [h264fua_pkg::CFG_ADDR_BITS-1:0] idx,
                           input logic [h264fua_pkg::PAYLOAD_BITS-1:0] val);
    in_valid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_PAYLOAD: max_payload_q = val;
      REG_SINGLE_NAL:  single_only_q = val[0];
      default: ;
    endcase
  endtask

  task automatic send_random_unit();
    int                                n;
    int                                nbytes;
    logic [h264fua_pkg::SIZE_BITS-1:0] len;
    if (sent_items >= ITEM_TARGET) return;
    case ($urandom_range(0, 9))
      0: begin
        // loose bytes: ignored when idle, otherwise continue whatever is open
        repeat ($urandom_range(1, 3))
          if (sent_items < ITEM_TARGET)
            push_byte(8'($urandom), 1'b0, h264fua_pkg::SIZE_BITS'($urandom),
                      1'($urandom), n);
        return;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       len = '0;
          1:       len = '1;
          default: len = h264fua_pkg::SIZE_BITS'($urandom);
        endcase
        nbytes = int'($urandom_range(1, 6));
      end
      2: begin
        len    = h264fua_pkg::SIZE_BITS'($urandom_range(2, 48));
        nbytes = int'($urandom_range(1, int'(len) - 1));
      end
      default: begin
        len    = ($urandom_range(0, 7) == 0) ?
                 h264fua_pkg::SIZE_BITS'($urandom_range(49, 400)) :
                 h264fua_pkg::SIZE_BITS'($urandom_range(1, 48));
        nbytes = int'(len);
      end
    endcase
    push_byte(8'($urandom), 1'b1, len, 1'($urandom), n);
    for (int i = 1; i < nbytes && sent_items < ITEM_TARGET; i++)
      push_byte(8'($urandom), 1'b0, h264fua_pkg::SIZE_BITS'($urandom), 1'($urandom), n);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // output transfer checker
  always @(posedge clk) begin
    payload_t exp_p;
    if (!rst && out_valid && !out_stall) begin
      if (payload_q.size() == 0) begin
        $error("payload byte %0h with nothing expected", data_byte);
        fail_count++;
      end else begin
        exp_p = payload_q.pop_front();
        check_field("data_byte", exp_p.res.data_byte, data_byte);
        check_field("packet_start", 8'(exp_p.res.packet_start), 8'(packet_start));
        check_field("packet_end", 8'(exp_p.res.packet_end), 8'(packet_end));
        check_field("rtp_marker", 8'(exp_p.res.rtp_marker), 8'(rtp_marker));
        check_field("drop_error", 8'(exp_p.res.drop_error), 8'(drop_error));
        check_field("run_last", 8'(exp_p.run_last), 8'(run_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stall before each transfer
  initial begin : drain_side
    int hold;
    forever begin
      hold = draw_wait(out_burst);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int                                   n;
    step_row_t                            row;
    payload_t                             typed_p;
    logic [h264fua_pkg::PAYLOAD_BITS-1:0] pay;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        push_byte(row.b, row.first, row.len, row.au, n);
        if (row.chk != CHK_PRED) begin
          repeat (n) void'(payload_q.pop_back());
          if (row.chk == CHK_ONE) begin
            typed_p.res      = row.res;
            typed_p.run_last = 1'b1;
            payload_q.push_back(typed_p);
          end
        end
      end
    end

    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       pay = h264fua_pkg::PAYLOAD_BITS'($urandom_range(0, 2));
        5:       pay = h264fua_pkg::PAYLOAD_BITS'($urandom_range(25, 600));
        6:       pay = h264fua_pkg::PAYLOAD_BITS'($urandom);
        7:       pay = '1;
        default: pay = h264fua_pkg::PAYLOAD_BITS'($urandom_range(3, 24));
      endcase
      write_reg(REG_MAX_PAYLOAD, pay);
      write_reg(REG_SINGLE_NAL, h264fua_pkg::PAYLOAD_BITS'($urandom_range(0, 3) == 0));
      repeat ($urandom_range(2, 6)) send_random_unit();
    end

    in_valid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### h264_fua_packetizer.f
sv/h264fua_pkg.sv
sv/h264fua_core.sv
sv/h264_fua_packetizer.sv
sv/h264fua_checker.sv
tb/tb_h264_fua_packetizer.sv
